// ===== src/ole_pkg.sv =====
package ole_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_W     = $clog2(CAPACITY + 1);

  typedef logic [VALUE_WIDTH-1:0] val_t;
  typedef logic [COUNT_W-1:0]     cnt_t;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_REMOVE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] count;
    logic       is_empty;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic apply;
  } ctrl_cmd_t;

endpackage

// ===== src/ole_ctrl.sv =====
module ole_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ole_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   out_free;

  assign out_free  = !out_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign rsp_valid = out_valid;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    cmd.load       = 1'b0;
    cmd.apply      = 1'b0;
    if (out_valid && !rsp_stall) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        // The result register must be free before the list is changed.
        if (out_free) begin
          cmd.apply      = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== src/ole_dpath.sv =====
module ole_dpath (
  input  logic               clk,
  input  logic               rst,
  input  ole_pkg::ctrl_cmd_t cmd,
  input  ole_pkg::req_t      req,
  output ole_pkg::rsp_t      rsp
);

  ole_pkg::val_t                   cells [ole_pkg::CAPACITY];
  ole_pkg::cnt_t                   cnt, cnt_next;
  ole_pkg::op_t                    op;
  ole_pkg::val_t                   val;
  logic [ole_pkg::CAPACITY-1:0]    match;
  logic [ole_pkg::CAPACITY-1:0]    shift_sel;
  ole_pkg::val_t                   v_in;
  ole_pkg::status_t                status_next;
  ole_pkg::rsp_t                   rsp_q;
  logic                            full;
  logic                            empty;
  logic                            found;

  assign v_in  = ole_pkg::val_t'($unsigned(req.value));
  assign full  = (cnt == ole_pkg::cnt_t'(ole_pkg::CAPACITY));
  assign empty = (cnt == '0);
  assign found = |match;
  assign rsp   = rsp_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= ole_pkg::op_t'(req.operation);
      val <= v_in;
    end
  end

  always_comb begin
    cnt_next    = cnt;
    status_next = ole_pkg::ST_DONE;
    case (op)
      ole_pkg::OP_PUSH_FRONT, ole_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_next = ole_pkg::ST_FULL;
        end else begin
          cnt_next = cnt + ole_pkg::cnt_t'(1);
        end
      end
      ole_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_next = ole_pkg::ST_EMPTY;
        end else begin
          cnt_next = cnt - ole_pkg::cnt_t'(1);
        end
      end
      ole_pkg::OP_REMOVE: begin
        if (!found) begin
          status_next = ole_pkg::ST_NOTFOUND;
        end else begin
          cnt_next = cnt - ole_pkg::cnt_t'(1);
        end
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.apply) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      rsp_q.status   <= status_next;
      rsp_q.count    <= 5'(cnt_next);
      rsp_q.is_empty <= (cnt_next == '0);
    end
  end

  for (genvar i = 0; i < ole_pkg::CAPACITY; i++) begin : g_cell
    // A cell other than the tail shifts toward the head when it sits at or behind the first match.
    localparam logic [ole_pkg::CAPACITY-1:0] LowMask =
      {ole_pkg::CAPACITY{1'b1}} >> (ole_pkg::CAPACITY - 1 - i);

    assign shift_sel[i] = |(match & LowMask);

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        match[i] <= (cells[i] == v_in) && (ole_pkg::cnt_t'(i) < cnt);
      end
    end

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.apply) begin
          case (op)
            ole_pkg::OP_PUSH_FRONT: begin
              if (!full) begin
                cells[i] <= val;
              end
            end
            ole_pkg::OP_PUSH_BACK: begin
              if (!full && empty) begin
                cells[i] <= val;
              end
            end
            ole_pkg::OP_POP_FRONT: begin
              if (!empty) begin
                cells[i] <= cells[i+1];
              end
            end
            ole_pkg::OP_REMOVE: begin
              if (shift_sel[i]) begin
                cells[i] <= cells[i+1];
              end
            end
            default: begin
              cells[i] <= cells[i];
            end
          endcase
        end
      end
    end else if (i == ole_pkg::CAPACITY - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (cmd.apply) begin
          case (op)
            ole_pkg::OP_PUSH_FRONT: begin
              if (!full) begin
                cells[i] <= cells[i-1];
              end
            end
            ole_pkg::OP_PUSH_BACK: begin
              if (!full && (ole_pkg::cnt_t'(i) == cnt)) begin
                cells[i] <= val;
              end
            end
            default: begin
              cells[i] <= cells[i];
            end
          endcase
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.apply) begin
          case (op)
            ole_pkg::OP_PUSH_FRONT: begin
              if (!full) begin
                cells[i] <= cells[i-1];
              end
            end
            ole_pkg::OP_PUSH_BACK: begin
              if (!full && (ole_pkg::cnt_t'(i) == cnt)) begin
                cells[i] <= val;
              end
            end
            ole_pkg::OP_POP_FRONT: begin
              if (!empty) begin
                cells[i] <= cells[i+1];
              end
            end
            ole_pkg::OP_REMOVE: begin
              if (shift_sel[i]) begin
                cells[i] <= cells[i+1];
              end
            end
            default: begin
              cells[i] <= cells[i];
            end
          endcase
        end
      end
    end
  end

endmodule

// ===== src/ordered_list_engine.sv =====
// An ordered list of up to CAPACITY values held in a row of cells, head at
// cell 0. A request word is accepted in the idle state, where the value is
// compared against every cell at once and the matches are registered; the
// apply state then shifts the row and updates the count. The result word
// then waits in an output register; a stalled result holds the engine in
// the apply state of the next request, so that request word is accepted
// but changes the list only once the previous result has left. There is no
// clearing pass after reset: cells beyond the count are never looked at.
module ordered_list_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ole_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ole_pkg::rsp_t rsp
);

  ole_pkg::ctrl_cmd_t cmd;

  ole_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  ole_dpath u_dpath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule
